// ----- sv/sfs_pkg.sv -----
// sfs_pkg: shared types, codes and the sequencer program of the sprite frame sequencer
`default_nettype none
package sfs_pkg;

    // item commands
    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_PLAY = 2'd1;
    localparam logic [1:0] CMD_STOP = 2'd2;
    localparam logic [1:0] CMD_SET  = 2'd3;

    // configuration register indexes
    localparam int unsigned CfgIdxW = 3;
    localparam logic [CfgIdxW-1:0] CFG_FRAME_WIDTH  = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_FRAME_HEIGHT = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_TILES_PER_ROW = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_PLAY_MODE    = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_LOOP_SPEED   = 3'd4;

    // play modes
    localparam logic [1:0] MODE_LOOP     = 2'd1;
    localparam logic [1:0] MODE_PINGPONG = 2'd2;

    localparam logic [31:0] LOOP_SPEED_RESET = 32'h0001_0000;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] elapsed;
        logic [7:0]  start_frame;
        logic [7:0]  end_frame;
        logic [7:0]  frame_index;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  current_frame;
        logic [19:0] rect_x;
        logic [19:0] rect_y;
        logic [11:0] rect_width;
        logic [11:0] rect_height;
        logic        playing;
    } t_out_item;

    // datapath operations
    typedef enum logic [2:0] {
        OP_NOP   = 3'd0,
        OP_EXEC  = 3'd1,
        OP_STEP  = 3'd2,
        OP_TFIN  = 3'd3,
        OP_RINIT = 3'd4,
        OP_DIV   = 3'd5,
        OP_EMIT  = 3'd6,
        OP_DUR   = 3'd7
    } t_op;

    // jump conditions
    typedef enum logic [2:0] {
        C_NEVER     = 3'd0,
        C_ALWAYS    = 3'd1,
        C_NO_ITEM   = 3'd2,
        C_PLAY      = 3'd3,
        C_NO_STEPS  = 3'd4,
        C_STEP_MORE = 3'd5,
        C_DIV_MORE  = 3'd6,
        C_OUT_BUSY  = 3'd7
    } t_cond;

    typedef logic [3:0] t_pc;

    localparam t_pc P_IDLE  = 4'd0;
    localparam t_pc P_EXEC  = 4'd1;
    localparam t_pc P_SKIP  = 4'd2;
    localparam t_pc P_STEP  = 4'd3;
    localparam t_pc P_TFIN  = 4'd4;
    localparam t_pc P_RINIT = 4'd5;
    localparam t_pc P_RDIV  = 4'd6;
    localparam t_pc P_EMIT  = 4'd7;
    localparam t_pc P_DONE  = 4'd8;
    localparam t_pc P_PDIV  = 4'd9;
    localparam t_pc P_DUR   = 4'd10;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
    } t_ctrl;

    // control store: taken jump goes to target, otherwise to the next step
    function automatic t_ctrl sfs_rom(input t_pc pc);
        t_ctrl w;
        case (pc)
            P_IDLE:  w = '{op: OP_NOP,   cond: C_NO_ITEM,   target: P_IDLE};
            P_EXEC:  w = '{op: OP_EXEC,  cond: C_PLAY,      target: P_PDIV};
            P_SKIP:  w = '{op: OP_NOP,   cond: C_NO_STEPS,  target: P_RINIT};
            P_STEP:  w = '{op: OP_STEP,  cond: C_STEP_MORE, target: P_STEP};
            P_TFIN:  w = '{op: OP_TFIN,  cond: C_NEVER,     target: P_IDLE};
            P_RINIT: w = '{op: OP_RINIT, cond: C_NEVER,     target: P_IDLE};
            P_RDIV:  w = '{op: OP_DIV,   cond: C_DIV_MORE,  target: P_RDIV};
            P_EMIT:  w = '{op: OP_EMIT,  cond: C_OUT_BUSY,  target: P_EMIT};
            P_DONE:  w = '{op: OP_NOP,   cond: C_ALWAYS,    target: P_IDLE};
            P_PDIV:  w = '{op: OP_DIV,   cond: C_DIV_MORE,  target: P_PDIV};
            P_DUR:   w = '{op: OP_DUR,   cond: C_ALWAYS,    target: P_RINIT};
            default: w = '{op: OP_NOP,   cond: C_ALWAYS,    target: P_IDLE};
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// ----- sv/sprite_frame_sequencer_unit.sv -----
// sprite_frame_sequencer_unit: microcoded sprite animation frame sequencer
// work per item: a play runs a 32-step divide, a running tick one step per frame transition
// (at most MAX_STEPS); stop, set frame and a stopped tick run neither
// one item at a time: the next item is taken once the result has been loaded
// into the output register and the sequencer is back in idle
// reset: synchronous active-low i_rst_n idles the sequencer, clears state, loads defaults
`default_nettype none
module sprite_frame_sequencer_unit #(
    parameter int MAX_FRAMES = 256,
    parameter int MAX_STEPS  = 64
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_valid,
    output logic                       o_stall,
    input  sfs_pkg::t_in_item          i_item,
    output logic                       o_valid,
    input  wire                        i_stall,
    output sfs_pkg::t_out_item         o_item,
    input  wire                        i_cfg_we,
    input  wire [sfs_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  wire [31:0]                 i_cfg_data
);
    import sfs_pkg::*;

    localparam int FrameMaxI = (MAX_FRAMES - 1 > 255) ? 255 : MAX_FRAMES - 1;
    localparam logic [7:0] FRAME_MAX = FrameMaxI[7:0];
    localparam int StepW = $clog2(MAX_STEPS + 1);
    localparam logic [StepW-1:0] STEP_CAP = StepW'(MAX_STEPS);

    // configuration
    logic [11:0] r_fw, r_fh;
    logic [8:0]  r_tiles;
    logic [1:0]  r_mode;
    logic [31:0] r_speed;

    // animation state
    logic [7:0]  r_frame, r_first, r_last;
    logic        r_back, r_running;
    logic [31:0] r_dur;
    logic signed [33:0] r_ttn, r_t;
    logic [StepW-1:0]   r_steps;

    // sequencer and shared divider
    t_pc         r_pc;
    t_in_item    r_item;
    logic [31:0] r_quo;
    logic [8:0]  r_rem, r_dvs;
    logic [5:0]  r_cnt;
    logic        r_out_valid;
    t_out_item   r_out;

    t_ctrl ctrl;
    logic  in_acc, out_free, cond_hit, step_go;

    assign ctrl     = sfs_rom(r_pc);
    assign o_stall  = (r_pc != P_IDLE);
    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;
    assign step_go  = r_t[33] && r_running && (r_steps < STEP_CAP);
    assign o_valid  = r_out_valid;
    assign o_item   = r_out;

    always_comb begin
        case (ctrl.cond)
            C_NEVER:     cond_hit = 1'b0;
            C_ALWAYS:    cond_hit = 1'b1;
            C_NO_ITEM:   cond_hit = !in_acc;
            C_PLAY:      cond_hit = (r_item.cmd == CMD_PLAY);
            C_NO_STEPS:  cond_hit = (r_item.cmd != CMD_TICK) || !r_running;
            C_STEP_MORE: cond_hit = step_go;
            C_DIV_MORE:  cond_hit = (r_cnt != 6'd1);
            C_OUT_BUSY:  cond_hit = !out_free;
            default:     cond_hit = 1'b0;
        endcase
    end

    // clamped command arguments
    logic [7:0] s_cl, e_cl, e_fix, idx_cl;
    logic [8:0] count;
    always_comb begin
        s_cl   = (r_item.start_frame > FRAME_MAX) ? FRAME_MAX : r_item.start_frame;
        e_cl   = (r_item.end_frame > FRAME_MAX) ? FRAME_MAX : r_item.end_frame;
        e_fix  = (e_cl < s_cl) ? s_cl : e_cl;
        idx_cl = (r_item.frame_index > FRAME_MAX) ? FRAME_MAX : r_item.frame_index;
        count  = {1'b0, e_fix} - {1'b0, s_cl} + 9'd1;
    end

    // one frame transition with the range end rules
    logic signed [9:0] f_s, first_s, last_s, nf;
    logic              nb, nrun;
    logic              pp, lp;
    always_comb begin
        f_s     = signed'({2'b00, r_frame});
        first_s = signed'({2'b00, r_first});
        last_s  = signed'({2'b00, r_last});
        lp      = (r_mode == MODE_LOOP);
        pp      = (r_mode == MODE_PINGPONG);
        nf      = r_back ? f_s - 10'sd1 : f_s + 10'sd1;
        nb      = r_back;
        nrun    = r_running;
        if (nf < first_s) begin
            if (lp) begin
                nf = last_s;
            end else if (pp) begin
                nf = first_s + 10'sd1;
                if (nf > last_s) begin
                    nf = last_s;
                end
                nb = !nb;
            end else begin
                nrun = 1'b0;
                nf   = first_s;
            end
        end
        if (nf > last_s) begin
            if (lp) begin
                nf = first_s;
            end else if (pp) begin
                nf = last_s - 10'sd1;
                if (nf < first_s) begin
                    nf = first_s;
                end
                nb = !nb;
            end else begin
                nrun = 1'b0;
                nf   = last_s;
            end
        end
    end

    // divider step and effective tiles per row
    logic [9:0] shifted, diff;
    logic       ge;
    logic [8:0] tiles_eff;
    always_comb begin
        shifted   = {r_rem, r_quo[31]};
        diff      = shifted - {1'b0, r_dvs};
        ge        = (shifted >= {1'b0, r_dvs});
        if (r_tiles == 9'd0) begin
            tiles_eff = 9'd1;
        end else if (r_tiles > 9'd256) begin
            tiles_eff = 9'd256;
        end else begin
            tiles_eff = r_tiles;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= P_IDLE;
            r_out_valid <= 1'b0;
            r_fw        <= '0;
            r_fh        <= '0;
            r_tiles     <= 9'd1;
            r_mode      <= '0;
            r_speed     <= LOOP_SPEED_RESET;
            r_frame     <= '0;
            r_first     <= '0;
            r_last      <= '0;
            r_back      <= 1'b0;
            r_running   <= 1'b0;
            r_dur       <= '0;
            r_ttn       <= '0;
        end else begin
            r_pc <= cond_hit ? ctrl.target : r_pc + t_pc'(1);

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FRAME_WIDTH:   r_fw    <= i_cfg_data[11:0];
                    CFG_FRAME_HEIGHT:  r_fh    <= i_cfg_data[11:0];
                    CFG_TILES_PER_ROW: r_tiles <= i_cfg_data[8:0];
                    CFG_PLAY_MODE:     r_mode  <= i_cfg_data[1:0];
                    CFG_LOOP_SPEED:    r_speed <= i_cfg_data;
                    default: ;
                endcase
            end

            // a waiting result leaves when taken, a new one is loaded in its place
            if (ctrl.op == OP_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end

            case (ctrl.op)
                OP_EXEC: begin
                    case (r_item.cmd)
                        CMD_TICK: begin
                            if (r_running) begin
                                r_t     <= r_ttn - signed'({2'b00, r_item.elapsed});
                                r_steps <= '0;
                            end
                        end
                        CMD_PLAY: begin
                            r_first   <= s_cl;
                            r_last    <= e_fix;
                            r_frame   <= s_cl;
                            r_running <= 1'b1;
                            r_quo     <= r_speed;
                            r_rem     <= '0;
                            r_dvs     <= count;
                            r_cnt     <= 6'd32;
                        end
                        CMD_STOP: r_running <= 1'b0;
                        CMD_SET:  r_frame   <= idx_cl;
                        default: ;
                    endcase
                end
                OP_STEP: begin
                    if (step_go) begin
                        r_frame   <= nf[7:0];
                        r_back    <= nb;
                        r_running <= nrun;
                        r_t       <= r_t + signed'({2'b00, r_dur});
                        r_steps   <= r_steps + StepW'(1);
                    end
                end
                OP_TFIN: r_ttn <= r_t[33] ? '0 : r_t;
                OP_RINIT: begin
                    r_quo <= {r_frame, 24'd0};
                    r_rem <= '0;
                    r_dvs <= tiles_eff;
                    r_cnt <= 6'd8;
                end
                OP_DIV: begin
                    r_rem <= ge ? diff[8:0] : shifted[8:0];
                    r_quo <= {r_quo[30:0], ge};
                    r_cnt <= r_cnt - 6'd1;
                end
                OP_DUR: begin
                    r_dur <= r_quo;
                    r_ttn <= signed'({2'b00, r_quo});
                end
                default: ;
            endcase
        end
    end

    // item and result payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item <= i_item;
        end
        if (ctrl.op == OP_EMIT && out_free) begin
            r_out.current_frame <= r_frame;
            r_out.rect_x        <= 20'(r_rem[7:0]) * 20'(r_fw);
            r_out.rect_y        <= 20'(r_quo[7:0]) * 20'(r_fh);
            r_out.rect_width    <= r_fw;
            r_out.rect_height   <= r_fh;
            r_out.playing       <= r_running;
        end
    end

endmodule
`default_nettype wire
